[rtl/ini_line_classifier_core_defines.svh]
// ---------------------------------------------------------------------------
// ini_line_classifier_core_defines.svh
// Assertion macros for the line classifier RTL.
// ---------------------------------------------------------------------------
`ifndef INI_LINE_CLASSIFIER_CORE_DEFINES_SVH
`define INI_LINE_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define INI_LC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ini_lc assertion failed");
// Clocked check that also holds during reset.
`define INI_LC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ini_lc assertion failed");
`else
`define INI_LC_ASSERT(lbl, prop)
`define INI_LC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/ini_lc_pkg.sv]
// ---------------------------------------------------------------------------
// ini_lc_pkg
// Shared constants, codes and the parse state type of the line classifier.
// ---------------------------------------------------------------------------
package ini_lc_pkg;

  localparam int MAX_LINE = 4096;
  localparam int POS_W    = $clog2(MAX_LINE);
  localparam int OUT_W    = 12;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE - 1);

  // parser phases
  localparam logic [3:0] PH_LEAD     = 4'd0;
  localparam logic [3:0] PH_SEC_LEAD = 4'd1;
  localparam logic [3:0] PH_SEC_BODY = 4'd2;
  localparam logic [3:0] PH_SEC_DONE = 4'd3;
  localparam logic [3:0] PH_CMT_WS   = 4'd4;
  localparam logic [3:0] PH_KEY      = 4'd5;
  localparam logic [3:0] PH_KEY_WS   = 4'd6;
  localparam logic [3:0] PH_VAL_LEAD = 4'd7;
  localparam logic [3:0] PH_VAL_BODY = 4'd8;
  localparam logic [3:0] PH_FAIL     = 4'd9;
  localparam logic [3:0] PH_SET_DONE = 4'd10;

  // class of the first non-blank character
  localparam logic [1:0] FC_NONE    = 2'd0;
  localparam logic [1:0] FC_SECTION = 2'd1;
  localparam logic [1:0] FC_COMMENT = 2'd2;
  localparam logic [1:0] FC_OTHER   = 2'd3;

  // line kinds
  localparam logic [2:0] KIND_BLANK    = 3'd0;
  localparam logic [2:0] KIND_SECTION  = 3'd1;
  localparam logic [2:0] KIND_CMT_SET  = 3'd2;
  localparam logic [2:0] KIND_COMMENT  = 3'd3;
  localparam logic [2:0] KIND_COMMAND  = 3'd4;
  localparam logic [2:0] KIND_SETTING  = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

  // line endings
  localparam logic [1:0] EOL_NONE = 2'd0;
  localparam logic [1:0] EOL_LF   = 2'd1;
  localparam logic [1:0] EOL_CR   = 2'd2;
  localparam logic [1:0] EOL_CRLF = 2'd3;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [3:0]       phase;
    logic [1:0]       fclass;
    logic [POS_W-1:0] key_b;
    logic [POS_W-1:0] key_e;
    logic [POS_W-1:0] val_b;
    logic [POS_W-1:0] val_e;
    logic [POS_W-1:0] cmt_pos;
    logic             cmt_found;
    logic [POS_W-1:0] name_b;
    logic [POS_W-1:0] name_e;
    logic             ovf;
  } parse_t;

  // Fit an offset to the 12-bit result fields.
  function automatic logic [OUT_W-1:0] to_out(input logic [POS_W-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[OUT_W-1:0];
  endfunction

endpackage

[rtl/ini_line_classifier_core.sv]
// ---------------------------------------------------------------------------
// ini_line_classifier_core
// Streaming classifier for one line of an INI-style configuration file.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one byte of a line per
//   beat, end-of-line bytes included; last_i marks the final byte and
//   in_autoexec_i is sampled with it. Only the last beat of a line yields
//   a result beat on the output channel (out_valid_o / out_ready_i), which
//   carries the kind, the stripped ending, the body length and offsets.
//   Throughput: one byte per cycle. Each beat goes through an input
//   register and then a single parse pass; the final beat runs up to three
//   chained parser steps (two held bytes plus itself) in that pass.
//   The last byte passes the input register, then the result register,
//   which raises out_valid_o; a stall can hold it in the input register.
//   The next line can start right behind the last byte of the previous one.
//   If the receiver stalls, the result is held in the output register and
//   bytes keep flowing until a second last byte reaches the parse stage;
//   that beat waits there and in_ready_o drops until the result is taken.
//   Reset clears the parse state, the two-byte hold buffer and both
//   valid flags, so the block can take a beat as soon as reset ends.
// ---------------------------------------------------------------------------
`include "ini_line_classifier_core_defines.svh"

module ini_line_classifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  input  logic        in_autoexec_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  line_kind_o,
  output logic [1:0]  eol_kind_o,
  output logic [11:0] body_length_o,
  output logic [11:0] key_first_o,
  output logic [11:0] key_stop_o,
  output logic [11:0] value_first_o,
  output logic [11:0] value_stop_o,
  output logic [11:0] comment_first_o,
  output logic        has_comment_o,
  output logic [11:0] section_first_o,
  output logic [11:0] section_stop_o,
  output logic        too_long_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       autoexec_q;

  // hold buffer and parse state
  logic [7:0]         held0_q, held0_d;
  logic [7:0]         held1_q, held1_d;
  logic [1:0]         held_cnt_q, held_cnt_d;
  ini_lc_pkg::parse_t parse_q, parse_d, parse_clr;
  ini_lc_pkg::parse_t st0, st1, st2;

  logic       advance;
  logic       prev_cr;
  logic [1:0] eol;
  logic [1:0] keep;
  logic       en0, en1, en2;
  logic [7:0] b0, b1;
  logic       setting_ok;
  logic [2:0] kind;

  // result register
  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [1:0]  eol_q;
  logic [11:0] len_q, key_b_q, key_e_q, val_b_q, val_e_q;
  logic [11:0] cmt_q, name_b_q, name_e_q;
  logic        has_cmt_q, ovf_q;

  // a last beat waits while an earlier result is still unclaimed
  assign advance    = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q       <= ch_i;
      last_q     <= last_i;
      autoexec_q <= in_autoexec_i;
    end
  end

  // closing line ending detection over held bytes and the current byte
  always_comb begin
    prev_cr = 1'b0;
    if (held_cnt_q == 2'd2) begin
      prev_cr = (held1_q == ini_lc_pkg::CH_CR);
    end else if (held_cnt_q == 2'd1) begin
      prev_cr = (held0_q == ini_lc_pkg::CH_CR);
    end
    if ((ch_q == ini_lc_pkg::CH_LF) && prev_cr) begin
      eol  = ini_lc_pkg::EOL_CRLF;
      keep = held_cnt_q - 2'd1;
    end else if (ch_q == ini_lc_pkg::CH_LF) begin
      eol  = ini_lc_pkg::EOL_LF;
      keep = held_cnt_q;
    end else if (ch_q == ini_lc_pkg::CH_CR) begin
      eol  = ini_lc_pkg::EOL_CR;
      keep = held_cnt_q;
    end else begin
      eol  = ini_lc_pkg::EOL_NONE;
      keep = held_cnt_q + 2'd1;
    end
  end

  assign b0  = (held_cnt_q == 2'd0) ? ch_q : held0_q;
  assign b1  = (held_cnt_q == 2'd2) ? held1_q : ch_q;
  assign en0 = last_q ? (keep != 2'd0) : (held_cnt_q == 2'd2);
  assign en1 = last_q && (keep >= 2'd2);
  assign en2 = last_q && (keep == 2'd3);

  ini_lc_step u_step0 (.state_i(parse_q), .ch_i(b0),   .en_i(en0), .state_o(st0));
  ini_lc_step u_step1 (.state_i(st0),     .ch_i(b1),   .en_i(en1), .state_o(st1));
  ini_lc_step u_step2 (.state_i(st1),     .ch_i(ch_q), .en_i(en2), .state_o(st2));

  always_comb begin
    parse_clr        = '0;
    parse_clr.phase  = ini_lc_pkg::PH_LEAD;
    parse_clr.fclass = ini_lc_pkg::FC_NONE;
  end

  always_comb begin
    parse_d    = parse_q;
    held0_d    = held0_q;
    held1_d    = held1_q;
    held_cnt_d = held_cnt_q;
    if (advance) begin
      if (last_q) begin
        parse_d    = parse_clr;
        held0_d    = 8'h00;
        held1_d    = 8'h00;
        held_cnt_d = 2'd0;
      end else begin
        parse_d = st2;
        // shift the oldest byte out to the parser once both slots fill
        if (held_cnt_q == 2'd2) begin
          held0_d = held1_q;
          held1_d = ch_q;
        end else if (held_cnt_q == 2'd1) begin
          held1_d    = ch_q;
          held_cnt_d = 2'd2;
        end else begin
          held0_d    = ch_q;
          held_cnt_d = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q    <= '0;
      held0_q    <= 8'h00;
      held1_q    <= 8'h00;
      held_cnt_q <= 2'd0;
    end else begin
      parse_q    <= parse_d;
      held0_q    <= held0_d;
      held1_q    <= held1_d;
      held_cnt_q <= held_cnt_d;
    end
  end

  // classify from the state after the final bytes
  always_comb begin
    setting_ok = st2.phase inside {ini_lc_pkg::PH_VAL_LEAD, ini_lc_pkg::PH_VAL_BODY,
                                   ini_lc_pkg::PH_SET_DONE};
    if (st2.phase == ini_lc_pkg::PH_LEAD) begin
      kind = ini_lc_pkg::KIND_BLANK;
    end else if (st2.fclass == ini_lc_pkg::FC_SECTION) begin
      kind = (st2.phase == ini_lc_pkg::PH_SEC_DONE) ? ini_lc_pkg::KIND_SECTION
                                                    : ini_lc_pkg::KIND_UNKNOWN;
    end else if (st2.fclass == ini_lc_pkg::FC_COMMENT) begin
      kind = setting_ok ? ini_lc_pkg::KIND_CMT_SET : ini_lc_pkg::KIND_COMMENT;
    end else if (autoexec_q) begin
      kind = ini_lc_pkg::KIND_COMMAND;
    end else begin
      kind = setting_ok ? ini_lc_pkg::KIND_SETTING : ini_lc_pkg::KIND_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      kind_q    <= kind;
      eol_q     <= eol;
      len_q     <= ini_lc_pkg::to_out(st2.pos);
      ovf_q     <= st2.ovf;
      key_b_q   <= 12'd0;
      key_e_q   <= 12'd0;
      val_b_q   <= 12'd0;
      val_e_q   <= 12'd0;
      cmt_q     <= 12'd0;
      has_cmt_q <= 1'b0;
      name_b_q  <= 12'd0;
      name_e_q  <= 12'd0;
      if ((kind == ini_lc_pkg::KIND_CMT_SET) || (kind == ini_lc_pkg::KIND_SETTING)) begin
        key_b_q <= ini_lc_pkg::to_out(st2.key_b);
        key_e_q <= ini_lc_pkg::to_out(st2.key_e);
        val_b_q <= ini_lc_pkg::to_out(st2.val_b);
        val_e_q <= ini_lc_pkg::to_out(st2.val_e);
      end
      if ((kind == ini_lc_pkg::KIND_SETTING) && st2.cmt_found) begin
        cmt_q     <= ini_lc_pkg::to_out(st2.cmt_pos);
        has_cmt_q <= 1'b1;
      end
      if (kind == ini_lc_pkg::KIND_SECTION) begin
        name_b_q <= ini_lc_pkg::to_out(st2.name_b);
        name_e_q <= ini_lc_pkg::to_out(st2.name_e);
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_kind_o     = kind_q;
  assign eol_kind_o      = eol_q;
  assign body_length_o   = len_q;
  assign key_first_o     = key_b_q;
  assign key_stop_o      = key_e_q;
  assign value_first_o   = val_b_q;
  assign value_stop_o    = val_e_q;
  assign comment_first_o = cmt_q;
  assign has_comment_o   = has_cmt_q;
  assign section_first_o = name_b_q;
  assign section_stop_o  = name_e_q;
  assign too_long_o      = ovf_q;

  `INI_LC_ASSERT_ALWAYS(a_held_cnt_range, !rst_ni || (held_cnt_q != 2'd3))
  `INI_LC_ASSERT(a_last_clears, (advance && last_q) |=>
                 (out_valid_q && (held_cnt_q == 2'd0) &&
                  (parse_q.phase == ini_lc_pkg::PH_LEAD)))
  `INI_LC_ASSERT(a_ovf_saturates, parse_q.ovf |-> (parse_q.pos == ini_lc_pkg::POS_MAX))
  `INI_LC_ASSERT(a_stall_cause, !in_ready_o |-> (in_valid_q && last_q && out_valid_q && !out_ready_i))

endmodule

[rtl/ini_lc_step.sv]
// ---------------------------------------------------------------------------
// ini_lc_step
// One parser step: advance the parse state by one body byte.
// ---------------------------------------------------------------------------
module ini_lc_step (
  input  ini_lc_pkg::parse_t state_i,
  input  logic [7:0]         ch_i,
  input  logic               en_i,
  output ini_lc_pkg::parse_t state_o
);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_RBR   = 8'h5D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_USCR  = 8'h5F;

  logic                         blank;
  logic                         word;
  logic                         cmt_ch;
  logic [ini_lc_pkg::POS_W-1:0] p;
  logic [ini_lc_pkg::POS_W-1:0] pp;

  assign p      = state_i.pos;
  assign pp     = (p >= ini_lc_pkg::POS_MAX) ? ini_lc_pkg::POS_MAX : p + 1'b1;
  assign blank  = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
  assign cmt_ch = (ch_i == CH_HASH) || (ch_i == CH_SEMI);
  assign word   = (ch_i inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
                  (ch_i == CH_USCR);

  always_comb begin
    state_o = state_i;
    if (en_i) begin
      // saturate the position and flag the overflow
      if (p >= ini_lc_pkg::POS_MAX) begin
        state_o.ovf = 1'b1;
      end else begin
        state_o.pos = p + 1'b1;
      end
      case (state_i.phase)
        ini_lc_pkg::PH_LEAD: begin
          if (!blank) begin
            if (ch_i == CH_LBR) begin
              state_o.fclass = ini_lc_pkg::FC_SECTION;
              state_o.name_b = pp;
              state_o.name_e = pp;
              state_o.phase  = ini_lc_pkg::PH_SEC_LEAD;
            end else if (cmt_ch) begin
              state_o.fclass = ini_lc_pkg::FC_COMMENT;
              state_o.phase  = ini_lc_pkg::PH_CMT_WS;
            end else begin
              state_o.fclass = ini_lc_pkg::FC_OTHER;
              if (word) begin
                state_o.key_b = p;
                state_o.key_e = pp;
                state_o.phase = ini_lc_pkg::PH_KEY;
              end else begin
                state_o.phase = ini_lc_pkg::PH_FAIL;
              end
            end
          end
        end
        ini_lc_pkg::PH_SEC_LEAD, ini_lc_pkg::PH_SEC_BODY: begin
          if (ch_i == CH_RBR) begin
            state_o.phase = ini_lc_pkg::PH_SEC_DONE;
          end else if (!blank) begin
            if (state_i.phase == ini_lc_pkg::PH_SEC_LEAD) begin
              state_o.name_b = p;
              state_o.phase  = ini_lc_pkg::PH_SEC_BODY;
            end
            state_o.name_e = pp;
          end
        end
        ini_lc_pkg::PH_CMT_WS: begin
          if (!blank) begin
            if (word) begin
              state_o.key_b = p;
              state_o.key_e = pp;
              state_o.phase = ini_lc_pkg::PH_KEY;
            end else begin
              state_o.phase = ini_lc_pkg::PH_FAIL;
            end
          end
        end
        ini_lc_pkg::PH_KEY: begin
          if (word) begin
            state_o.key_e = pp;
          end else if (blank) begin
            state_o.phase = ini_lc_pkg::PH_KEY_WS;
          end else if (ch_i == CH_EQ) begin
            state_o.val_b = pp;
            state_o.val_e = pp;
            state_o.phase = ini_lc_pkg::PH_VAL_LEAD;
          end else begin
            state_o.phase = ini_lc_pkg::PH_FAIL;
          end
        end
        ini_lc_pkg::PH_KEY_WS: begin
          if (!blank) begin
            if (ch_i == CH_EQ) begin
              state_o.val_b = pp;
              state_o.val_e = pp;
              state_o.phase = ini_lc_pkg::PH_VAL_LEAD;
            end else begin
              state_o.phase = ini_lc_pkg::PH_FAIL;
            end
          end
        end
        ini_lc_pkg::PH_VAL_LEAD, ini_lc_pkg::PH_VAL_BODY: begin
          // trailing comments only end plain settings
          if ((state_i.fclass == ini_lc_pkg::FC_OTHER) && cmt_ch) begin
            state_o.cmt_pos   = p;
            state_o.cmt_found = 1'b1;
            state_o.phase     = ini_lc_pkg::PH_SET_DONE;
          end else if (!blank) begin
            if (state_i.phase == ini_lc_pkg::PH_VAL_LEAD) begin
              state_o.val_b = p;
              state_o.phase = ini_lc_pkg::PH_VAL_BODY;
            end
            state_o.val_e = pp;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
